@@ rtl/core/ray_box_slab_intersect_defines.svh @@
// Assertion macros for the slab-intersection RTL (used by rbsi_fifo).
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define RBSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define RBSI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/core/rbsi_pkg.sv @@
// Package for the ray/box slab intersection block: widths, register indexes,
// shared types and saturation helpers. No dependencies.
`default_nettype none

package rbsi_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int AXES         = 3;
  // The reciprocal divides 2^(2*FRAC_BITS), a dividend of this many bits.
  localparam int DIV_BITS     = 2 * FRAC_BITS + 1;
  localparam int PROD_BITS    = 2 * WORD_BITS;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_BITS = 3;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Z = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_X = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Y = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Z = CFG_IDX_BITS'(5);

  typedef logic [AXES-1:0][WORD_BITS-1:0] vec_t;

  // A classified ray as it waits in the queue.
  typedef struct packed {
    vec_t                 dn;    // near corner minus origin, saturated
    vec_t                 df;    // far corner minus origin, saturated
    vec_t                 dir;
    logic [WORD_BITS-1:0] near;
    logic [WORD_BITS-1:0] far;
  } item_t;

  // One step of the reciprocal divider.
  typedef struct packed {
    logic [AXES-1:0][WORD_BITS-1:0] rem;
    logic [AXES-1:0][DIV_BITS-1:0]  quo;
    logic [AXES-1:0][WORD_BITS-1:0] dmag;
    logic [AXES-1:0]                dneg;
    logic [AXES-1:0]                dzero;
    vec_t                           dn;
    vec_t                           df;
    logic [WORD_BITS-1:0]           near;
    logic [WORD_BITS-1:0]           far;
  } div_t;

  // Reciprocals ready for the multipliers.
  typedef struct packed {
    vec_t                 r;
    vec_t                 dn;
    vec_t                 df;
    logic [WORD_BITS-1:0] near;
    logic [WORD_BITS-1:0] far;
  } recip_t;

  function automatic logic [WORD_BITS-1:0] sat_diff(input logic signed [WORD_BITS:0] v);
    logic signed [WORD_BITS:0] hi_lim;
    logic signed [WORD_BITS:0] lo_lim;
    hi_lim = (WORD_BITS+1)'($signed(WORD_MAX));
    lo_lim = (WORD_BITS+1)'($signed(WORD_MIN));
    if (v > hi_lim) return WORD_MAX;
    if (v < lo_lim) return WORD_MIN;
    return v[WORD_BITS-1:0];
  endfunction

  // Arithmetic shift floors toward minus infinity, then clamp to a word.
  function automatic logic [WORD_BITS-1:0] sat_prod(input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] s;
    logic signed [PROD_BITS-1:0] hi_lim;
    logic signed [PROD_BITS-1:0] lo_lim;
    s      = p >>> FRAC_BITS;
    hi_lim = PROD_BITS'($signed(WORD_MAX));
    lo_lim = PROD_BITS'($signed(WORD_MIN));
    if (s > hi_lim) return WORD_MAX;
    if (s < lo_lim) return WORD_MIN;
    return s[WORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rbsi_if.sv @@
// Valid/ready channel interfaces for ray words and result words.
// Depends on rbsi_pkg for the word width.
`default_nettype none

interface rbsi_ray_if;
  logic                          valid;
  logic                          ready;
  logic [rbsi_pkg::WORD_BITS-1:0] origin_x;
  logic [rbsi_pkg::WORD_BITS-1:0] origin_y;
  logic [rbsi_pkg::WORD_BITS-1:0] origin_z;
  logic [rbsi_pkg::WORD_BITS-1:0] dir_x;
  logic [rbsi_pkg::WORD_BITS-1:0] dir_y;
  logic [rbsi_pkg::WORD_BITS-1:0] dir_z;
  logic [rbsi_pkg::WORD_BITS-1:0] near_limit;
  logic [rbsi_pkg::WORD_BITS-1:0] far_limit;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  near_limit, far_limit, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  near_limit, far_limit, output ready);
endinterface

interface rbsi_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [rbsi_pkg::WORD_BITS-1:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink   (input valid, hit, hit_distance, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ray_box_slab_intersect.sv @@
// Top level of the ray against axis-aligned box slab test.
// Uses rbsi_pkg, rbsi_if, rbsi_front, rbsi_fifo and rbsi_back.
//
// The box corners sit in six registers written through cfg_we_i, cfg_idx_i
// and cfg_data_i: index 0..2 is the lower corner x, y, z and 3..5 the upper
// corner. Other indexes are ignored. Write them only while no ray is in flight.
// Rays arrive as words on ray_i (origin, direction, distance window, all
// signed Q16.16) and each produces exactly one result word on res_o: a hit
// flag and the entry distance, or zero when the slabs do not overlap.
// A ray is taken on every cycle in which the four-entry queue has room, so
// the block sustains one word per cycle while res_o.ready stays high. From
// acceptance to a valid result a ray passes the queue, the one-bit-per-stage
// reciprocal divider, then a register each for the reciprocal sign and clamp,
// the multiply, the product clamp, the x and y narrowing, and the z narrowing
// into the result register.
// While a result waits and res_o.ready is low the back end freezes in place;
// the queue keeps accepting until it fills, then ray_i.ready drops.
// Reset clears the box registers to zero and empties the queue and pipeline.
`default_nettype none

module ray_box_slab_intersect (
  input  var logic                                clk_i,
  input  var logic                                rst_ni,
  input  var logic                                cfg_we_i,
  input  var logic [rbsi_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  var logic [rbsi_pkg::WORD_BITS-1:0]      cfg_data_i,
  rbsi_ray_if.sink                                ray_i,
  rbsi_hit_if.source                              res_o
);

  rbsi_pkg::vec_t  box_min_q;
  rbsi_pkg::vec_t  box_max_q;

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  rbsi_pkg::item_t push_item;
  rbsi_pkg::item_t head_item;

  // Corner registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= '0;
      box_max_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbsi_pkg::REG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rbsi_front u_front (
    .ray_i     (ray_i),
    .box_min_i (box_min_q),
    .box_max_i (box_max_q),
    .full_i    (full),
    .push_o    (push),
    .item_o    (push_item)
  );

  rbsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  rbsi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/rbsi_front.sv @@
// Front end: takes ray words, picks near and far corners by direction sign
// and forms the saturated corner-minus-origin offsets. Uses rbsi_pkg, rbsi_if.
`default_nettype none

module rbsi_front (
  rbsi_ray_if.sink                     ray_i,
  input  var rbsi_pkg::vec_t           box_min_i,
  input  var rbsi_pkg::vec_t           box_max_i,
  input  var logic                     full_i,
  output var logic                     push_o,
  output var rbsi_pkg::item_t          item_o
);

  rbsi_pkg::vec_t org;
  rbsi_pkg::vec_t dir;

  assign org = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
  assign dir = {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};

  assign ray_i.ready = !full_i;
  assign push_o      = ray_i.valid && !full_i;

  always_comb begin
    logic [rbsi_pkg::WORD_BITS-1:0] lo;
    logic [rbsi_pkg::WORD_BITS-1:0] hi;
    item_o = '0;
    for (int a = 0; a < rbsi_pkg::AXES; a++) begin
      // A negative direction has a negative reciprocal, so the corners swap.
      lo = dir[a][rbsi_pkg::WORD_BITS-1] ? box_max_i[a] : box_min_i[a];
      hi = dir[a][rbsi_pkg::WORD_BITS-1] ? box_min_i[a] : box_max_i[a];
      item_o.dn[a] = rbsi_pkg::sat_diff($signed({lo[rbsi_pkg::WORD_BITS-1], lo})
                                      - $signed({org[a][rbsi_pkg::WORD_BITS-1], org[a]}));
      item_o.df[a] = rbsi_pkg::sat_diff($signed({hi[rbsi_pkg::WORD_BITS-1], hi})
                                      - $signed({org[a][rbsi_pkg::WORD_BITS-1], org[a]}));
    end
    item_o.dir  = dir;
    item_o.near = ray_i.near_limit;
    item_o.far  = ray_i.far_limit;
  end

endmodule

`default_nettype wire

@@ rtl/core/rbsi_fifo.sv @@
// Short queue of classified rays between the front and back ends.
// Uses rbsi_pkg and the assertion macros.
`default_nettype none
`include "ray_box_slab_intersect_defines.svh"

module rbsi_fifo (
  input  var logic            clk_i,
  input  var logic            rst_ni,
  input  var logic            push_i,
  input  var rbsi_pkg::item_t item_i,
  input  var logic            pop_i,
  output var rbsi_pkg::item_t item_o,
  output var logic            full_o,
  output var logic            empty_o
);

  localparam int CW = rbsi_pkg::FIFO_AW + 1;

  rbsi_pkg::item_t                mem_q [rbsi_pkg::FIFO_DEPTH];
  logic [rbsi_pkg::FIFO_AW-1:0]   wr_q, wr_d;
  logic [rbsi_pkg::FIFO_AW-1:0]   rd_q, rd_d;
  logic [CW-1:0]                  count_q, count_d;

  assign full_o  = (count_q == CW'(rbsi_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == rbsi_pkg::FIFO_AW'(rbsi_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == rbsi_pkg::FIFO_AW'(rbsi_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `RBSI_NEVER(a_fifo_bound, count_q > CW'(rbsi_pkg::FIFO_DEPTH), "queue count beyond depth")
  `RBSI_NEVER(a_fifo_underrun, pop_i && empty_o, "pop from empty queue")
  `RBSI_NEVER(a_fifo_overrun, push_i && full_o, "push into full queue")
  `RBSI_ASSERT(a_fifo_count, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "count did not grow on push")

endmodule

`default_nettype wire

@@ rtl/core/rbsi_recip.sv @@
// Pipelined restoring divider: one quotient bit per stage forms
// 2^(2*FRAC_BITS) / |dir| for all three axes, then signs and saturates it.
// Uses rbsi_pkg.
`default_nettype none

module rbsi_recip (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var logic             en_i,
  input  var logic             valid_i,
  input  var rbsi_pkg::item_t  item_i,
  output var logic             valid_o,
  output var rbsi_pkg::recip_t recip_o
);

  localparam int W  = rbsi_pkg::WORD_BITS;
  localparam int QW = rbsi_pkg::DIV_BITS;
  localparam int N  = rbsi_pkg::DIV_BITS;

  rbsi_pkg::div_t   init;
  rbsi_pkg::div_t   stg_q [N];
  logic [N-1:0]     vld_q;
  rbsi_pkg::recip_t fin_d, fin_q;
  logic             fin_vld_q;

  always_comb begin
    init = '0;
    for (int a = 0; a < rbsi_pkg::AXES; a++) begin
      init.dneg[a]  = item_i.dir[a][W-1];
      init.dzero[a] = (item_i.dir[a] == '0);
      init.dmag[a]  = item_i.dir[a][W-1] ? (~item_i.dir[a] + 1'b1) : item_i.dir[a];
    end
    init.dn   = item_i.dn;
    init.df   = item_i.df;
    init.near = item_i.near;
    init.far  = item_i.far;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    // Only the leading dividend bit is set.
    localparam logic NBIT = (i == 0);
    rbsi_pkg::div_t src;
    rbsi_pkg::div_t nxt;

    if (i == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = stg_q[i-1];
    end

    always_comb begin
      logic [W:0] sh;
      nxt = src;
      for (int a = 0; a < rbsi_pkg::AXES; a++) begin
        sh = {src.rem[a], NBIT};
        if (sh >= {1'b0, src.dmag[a]}) begin
          nxt.rem[a] = W'(sh - {1'b0, src.dmag[a]});
          nxt.quo[a] = {src.quo[a][QW-2:0], 1'b1};
        end else begin
          nxt.rem[a] = sh[W-1:0];
          nxt.quo[a] = {src.quo[a][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= (i == 0) ? valid_i : vld_q[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[i] <= nxt;
      end
    end
  end

  always_comb begin
    logic [W+QW-1:0] qe;
    fin_d      = '0;
    fin_d.dn   = stg_q[N-1].dn;
    fin_d.df   = stg_q[N-1].df;
    fin_d.near = stg_q[N-1].near;
    fin_d.far  = stg_q[N-1].far;
    for (int a = 0; a < rbsi_pkg::AXES; a++) begin
      qe = (W+QW)'(stg_q[N-1].quo[a]);
      if (stg_q[N-1].dzero[a]) begin
        fin_d.r[a] = rbsi_pkg::WORD_MAX;
      end else if (stg_q[N-1].dneg[a]) begin
        fin_d.r[a] = (qe > (W+QW)'(rbsi_pkg::WORD_MIN)) ? rbsi_pkg::WORD_MIN
                                                       : ~qe[W-1:0] + 1'b1;
      end else begin
        fin_d.r[a] = (qe > (W+QW)'(rbsi_pkg::WORD_MAX)) ? rbsi_pkg::WORD_MAX : qe[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (en_i) begin
      fin_vld_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fin_q <= fin_d;
    end
  end

  assign valid_o = fin_vld_q;
  assign recip_o = fin_q;

endmodule

`default_nettype wire

@@ rtl/core/rbsi_back.sv @@
// Back end: reciprocal pipeline, six slab products, interval narrowing
// and the window test into the result register. Uses rbsi_pkg, rbsi_if.
`default_nettype none

module rbsi_back (
  input  var logic            clk_i,
  input  var logic            rst_ni,
  input  var logic            empty_i,
  input  var rbsi_pkg::item_t item_i,
  output var logic            pop_o,
  rbsi_hit_if.source          res_o
);

  localparam int W  = rbsi_pkg::WORD_BITS;
  localparam int PW = rbsi_pkg::PROD_BITS;

  logic             en;
  logic             rc_vld;
  rbsi_pkg::recip_t rc;

  logic signed [PW-1:0] pn_q [rbsi_pkg::AXES];
  logic signed [PW-1:0] pf_q [rbsi_pkg::AXES];
  logic [W-1:0]         lim_n1_q, lim_f1_q, lim_n2_q, lim_f2_q, lim_n3_q, lim_f3_q;
  logic                 mul_vld_q;

  rbsi_pkg::vec_t tn_q, tf_q;
  logic           sat_vld_q;

  logic [W-1:0] xy_n_q, xy_f_q, z_n_q, z_f_q;
  logic         xy_rej_q;
  logic         xy_vld_q;

  logic         out_vld_q;
  logic         hit_q;
  logic [W-1:0] dist_q;

  // The whole back end advances together unless the result is held.
  assign en    = !out_vld_q || res_o.ready;
  assign pop_o = en && !empty_i;

  rbsi_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (!empty_i),
    .item_i  (item_i),
    .valid_o (rc_vld),
    .recip_o (rc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sat_vld_q <= 1'b0;
      xy_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= rc_vld;
      sat_vld_q <= mul_vld_q;
      xy_vld_q  <= sat_vld_q;
      out_vld_q <= xy_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < rbsi_pkg::AXES; a++) begin
        pn_q[a] <= $signed(rc.dn[a]) * $signed(rc.r[a]);
        pf_q[a] <= $signed(rc.df[a]) * $signed(rc.r[a]);
        tn_q[a] <= rbsi_pkg::sat_prod(pn_q[a]);
        tf_q[a] <= rbsi_pkg::sat_prod(pf_q[a]);
      end
      lim_n1_q <= rc.near;
      lim_f1_q <= rc.far;
      lim_n2_q <= lim_n1_q;
      lim_f2_q <= lim_f1_q;
      lim_n3_q <= lim_n2_q;
      lim_f3_q <= lim_f2_q;

      // x and y slabs: reject on no overlap, otherwise narrow.
      xy_rej_q <= ($signed(tn_q[0]) > $signed(tf_q[1]))
               || ($signed(tn_q[1]) > $signed(tf_q[0]));
      xy_n_q   <= ($signed(tn_q[1]) > $signed(tn_q[0])) ? tn_q[1] : tn_q[0];
      xy_f_q   <= ($signed(tf_q[1]) < $signed(tf_q[0])) ? tf_q[1] : tf_q[0];
      z_n_q    <= tn_q[2];
      z_f_q    <= tf_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    logic         rej;
    logic [W-1:0] t;
    if (en) begin
      rej = xy_rej_q || ($signed(xy_n_q) > $signed(z_f_q))
                     || ($signed(z_n_q) > $signed(xy_f_q));
      t   = ($signed(z_n_q) > $signed(xy_n_q)) ? z_n_q : xy_n_q;
      hit_q  <= !rej && ($signed(t) >= $signed(lim_n3_q)) && ($signed(t) <= $signed(lim_f3_q));
      dist_q <= rej ? '0 : t;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.hit          = hit_q;
  assign res_o.hit_distance = dist_q;

endmodule

`default_nettype wire

@@ sim/ray_box_slab_intersect_tb.sv @@
// Self-checking testbench for ray_box_slab_intersect: drives rays, predicts
// every result word and compares it. Depends on rbsi_pkg, rbsi_if and the RTL.
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;
  import rbsi_pkg::*;

  localparam int  HALF_PERIOD = 2;
  localparam int  CYCLE_LIMIT = 300000;
  localparam int  DRAIN_TAIL  = 45;
  localparam longint WMAX_L   = 64'sd2147483647;
  localparam longint WMIN_L   = -64'sd2147483648;
  localparam logic [WORD_BITS-1:0] ONE_Q = 32'h0001_0000;

  // Indexes past the last box register; the block must ignore writes there.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(6);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = CFG_IDX_BITS'(7);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct {
    word_t ox, oy, oz, dx, dy, dz, lim_near, lim_far;
  } ray_word_t;

  typedef struct {
    logic  hit;
    word_t hit_dist;
  } hit_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  word_t cfg_data_i = '0;

  rbsi_ray_if ray_bus ();
  rbsi_hit_if res_bus ();

  ray_box_slab_intersect u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ray_i      (ray_bus),
    .res_o      (res_bus)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // The predictor keeps its own copy of the box corners, updated at the
  // same clock edge at which the block takes the register write.
  longint box_lo [3];
  longint box_hi [3];

  ray_word_t pending_rays [$];
  hit_word_t expected_hits [$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        cycle_count = 0;

  function automatic longint clamp_word(longint v);
    if (v > WMAX_L) return WMAX_L;
    if (v < WMIN_L) return WMIN_L;
    return v;
  endfunction

  // Reciprocal of a direction component in Q16.16, truncated toward zero.
  function automatic longint recip_q(longint d);
    if (d == 0) return WMAX_L;
    return clamp_word((64'sd1 <<< (2 * FRAC_BITS)) / d);
  endfunction

  // Fixed-point product; the arithmetic shift floors toward minus infinity.
  function automatic longint mul_q(longint a, longint b);
    longint p;
    p = a * b;
    return clamp_word(p >>> FRAC_BITS);
  endfunction

  function automatic void slab_span(int axis, word_t org_w, word_t dir_w,
                                    output longint t_in, output longint t_out);
    longint r, lo, hi, org, tmp;
    org = longint'($signed(org_w));
    r   = recip_q(longint'($signed(dir_w)));
    lo  = box_lo[axis];
    hi  = box_hi[axis];
    if (r < 0) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    t_in  = mul_q(clamp_word(lo - org), r);
    t_out = mul_q(clamp_word(hi - org), r);
  endfunction

  function automatic hit_word_t predict_hit(ray_word_t rw);
    hit_word_t res;
    longint tn, tf, yn, yf, zn, zf;
    res.hit      = 1'b0;
    res.hit_dist = '0;
    slab_span(0, rw.ox, rw.dx, tn, tf);
    slab_span(1, rw.oy, rw.dy, yn, yf);
    // A ray that misses the overlap of the x and y slabs is rejected outright.
    if (tn > yf || yn > tf) return res;
    if (yn > tn) tn = yn;
    if (yf < tf) tf = yf;
    slab_span(2, rw.oz, rw.dz, zn, zf);
    if (tn > zf || zn > tf) return res;
    if (zn > tn) tn = zn;
    res.hit      = (tn >= longint'($signed(rw.lim_near)) &&
                    tn <= longint'($signed(rw.lim_far)));
    res.hit_dist = word_t'(tn);
    return res;
  endfunction

  // Driver: a new word is presented only once the previous one was taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_bus.valid <= 1'b0;
    end else if (!ray_bus.valid || ray_bus.ready) begin
      if (pending_rays.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        ray_word_t rw;
        rw = pending_rays.pop_front();
        ray_bus.valid      <= 1'b1;
        ray_bus.origin_x   <= rw.ox;
        ray_bus.origin_y   <= rw.oy;
        ray_bus.origin_z   <= rw.oz;
        ray_bus.dir_x      <= rw.dx;
        ray_bus.dir_y      <= rw.dy;
        ray_bus.dir_z      <= rw.dz;
        ray_bus.near_limit <= rw.lim_near;
        ray_bus.far_limit  <= rw.lim_far;
      end else begin
        ray_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on every accepted ray and checks every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ray_bus.valid && ray_bus.ready) begin
        ray_word_t rw;
        rw.ox = ray_bus.origin_x;
        rw.oy = ray_bus.origin_y;
        rw.oz = ray_bus.origin_z;
        rw.dx = ray_bus.dir_x;
        rw.dy = ray_bus.dir_y;
        rw.dz = ray_bus.dir_z;
        rw.lim_near = ray_bus.near_limit;
        rw.lim_far  = ray_bus.far_limit;
        expected_hits.push_back(predict_hit(rw));
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result word hit=%0b dist=%h", $time,
                   res_bus.hit, res_bus.hit_distance);
          fail_count++;
        end else begin
          hit_word_t want;
          want = expected_hits.pop_front();
          if (res_bus.hit !== want.hit) begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time,
                     want.hit, res_bus.hit);
            fail_count++;
          end
          if (res_bus.hit_distance !== want.hit_dist) begin
            $display("%0t: hit_distance mismatch expected %h actual %h", $time,
                     want.hit_dist, res_bus.hit_distance);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic word_t q_int(int v);
    return word_t'(v * 65536);
  endfunction

  task automatic push_ray(word_t ox, word_t oy, word_t oz, word_t dx, word_t dy,
                          word_t dz, word_t n, word_t f);
    ray_word_t rw;
    rw.ox = ox; rw.oy = oy; rw.oz = oz;
    rw.dx = dx; rw.dy = dy; rw.dz = dz;
    rw.lim_near = n; rw.lim_far = f;
    pending_rays.push_back(rw);
  endtask

  // One register write; the model follows at the edge that takes it.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx < REG_BOX_MAX_X) box_lo[idx] = longint'($signed(val));
    else if (idx <= REG_BOX_MAX_Z) box_hi[idx - REG_BOX_MAX_X] = longint'($signed(val));
  endtask

  task automatic load_box(word_t lx, word_t ly, word_t lz, word_t hx, word_t hy,
                          word_t hz);
    write_reg(REG_BOX_MIN_X, lx);
    write_reg(REG_BOX_MIN_Y, ly);
    write_reg(REG_BOX_MIN_Z, lz);
    write_reg(REG_BOX_MAX_X, hx);
    write_reg(REG_BOX_MAX_Y, hy);
    write_reg(REG_BOX_MAX_Z, hz);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every queued ray is sent, every predicted result has been seen
  // and no word is left waiting on the input channel.
  task automatic drain();
    while (pending_rays.size() > 0 || expected_hits.size() > 0 || ray_bus.valid)
      @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  function automatic word_t rand_coord();
    return word_t'($urandom_range(0, 16 * 65536)) - q_int(8);
  endfunction

  function automatic word_t rand_dir();
    int pick;
    word_t mag;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return word_t'($urandom);
    mag = word_t'($urandom_range(256, 2 * 65536));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Mostly rays aimed near the box with sensible windows; the rest is noise.
  task automatic push_random_ray();
    word_t n, f;
    if ($urandom_range(0, 9) == 0) begin
      push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
    end else begin
      n = word_t'($urandom_range(0, 2 * 65536)) - ONE_Q;
      case ($urandom_range(0, 5))
        0:       f = word_t'($urandom);
        1:       f = n - word_t'($urandom_range(1, 65536));
        default: f = n + word_t'($urandom_range(0, 24 * 65536));
      endcase
      push_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
               rand_dir(), n, f);
    end
  endtask

  initial begin
    word_t wmax_w, wmin_w;
    int idle_send [5];
    int idle_recv [5];
    wmax_w = WORD_MAX;
    wmin_w = WORD_MIN;
    idle_send = '{0, 49, 0, 26, 0};
    idle_recv = '{0, 0, 49, 26, 0};
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rays against a box of -1.0 to 1.0 on every axis. The spare
    // indexes are written too; the block must leave the box alone.
    write_reg(REG_SPARE_LO, wmax_w);
    write_reg(REG_SPARE_HI, wmin_w);
    load_box(-ONE_Q, -ONE_Q, -ONE_Q, ONE_Q, ONE_Q, ONE_Q);
    // Straight hit along +x with two zero direction components.
    push_ray(q_int(-4), 0, 0, ONE_Q, 0, 0, 0, q_int(10));
    // Negative direction swaps near and far corners.
    push_ray(q_int(4), 0, 0, -ONE_Q, 0, 0, 0, q_int(10));
    // Miss in y; rejection clears the distance.
    push_ray(q_int(-4), q_int(5), 0, ONE_Q, 0, 0, 0, q_int(10));
    // Miss in z after x and y overlap.
    push_ray(q_int(-4), 0, q_int(5), ONE_Q, 0, 0, 0, q_int(10));
    // Overlap but the entry lies outside the window.
    push_ray(q_int(-4), 0, 0, ONE_Q, 0, 0, q_int(5), q_int(10));
    // Reversed window.
    push_ray(q_int(-4), 0, 0, ONE_Q, 0, 0, q_int(10), 0);
    // Window collapsed onto the entry distance, both edges inclusive.
    push_ray(q_int(-4), 0, 0, ONE_Q, 0, 0, q_int(3), q_int(3));
    // Diagonal ray with mixed signs.
    push_ray(q_int(-3), q_int(3), q_int(-3), ONE_Q, -ONE_Q, ONE_Q, wmin_w, wmax_w);
    // Tiny and extreme directions saturate the reciprocal and products.
    push_ray(q_int(-4), 0, 0, 32'h1, 32'h1, 32'h1, wmin_w, wmax_w);
    push_ray(q_int(4), 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, wmin_w, wmax_w);
    push_ray(0, 0, 0, wmin_w, wmin_w, wmin_w, wmin_w, wmax_w);
    push_ray(0, 0, 0, wmax_w, wmax_w, wmax_w, wmin_w, wmax_w);
    // Extreme origins saturate the corner differences.
    push_ray(wmin_w, wmin_w, wmin_w, wmin_w, wmin_w, wmin_w, wmin_w, wmin_w);
    push_ray(wmax_w, wmax_w, wmax_w, wmax_w, wmax_w, wmax_w, wmax_w, wmax_w);
    push_ray(wmax_w, wmin_w, wmax_w, -ONE_Q, ONE_Q, 0, wmin_w, wmax_w);
    push_ray(0, 0, 0, 0, 0, 0, wmin_w, wmax_w);
    push_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Random phases, each with its own box; some also idle the sender or stall the receiver.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_box(-ONE_Q, -ONE_Q, -ONE_Q, q_int(2), q_int(2), q_int(2));
        1: load_box(wmin_w, wmin_w, wmin_w, wmax_w, wmax_w, wmax_w);
        2: load_box(0, 0, 0, 0, 0, 0);
        3: load_box(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
        default: load_box(wmax_w, wmax_w, wmin_w, wmin_w, wmin_w, wmax_w);
      endcase
      send_idle_pct  = idle_send[ph];
      recv_stall_pct = idle_recv[ph];
      for (int k = 0; k < 130; k++) push_random_ray();
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_if.sv
rtl/core/rbsi_front.sv
rtl/core/rbsi_fifo.sv
rtl/core/rbsi_recip.sv
rtl/core/rbsi_back.sv
rtl/core/ray_box_slab_intersect.sv
sim/ray_box_slab_intersect_tb.sv
